// ----- rtl/u8d_pkg.sv -----
// Package for the UTF-8 stream decoder: result entry and burst list types,
// sequence length codes and decode masks. No dependencies.
`default_nettype none

package u8d_pkg;

  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;

  // expected_length codes
  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // byte class prefixes
  localparam logic [1:0] TAIL_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // range limits
  localparam logic [CP_W-1:0] MIN_CP2  = 21'h00080;
  localparam logic [CP_W-1:0] MIN_CP3  = 21'h00800;
  localparam logic [CP_W-1:0] MIN_CP4  = 21'h10000;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [4:0]      SURR_TAG = 5'b11011;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            inv;
  } u8d_res_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    u8d_res_t [MAX_RES-1:0]    ent;
  } u8d_list_t;

endpackage

`default_nettype wire

// ----- rtl/u8d_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on u8d_pkg for field widths.
`default_nettype none

interface u8d_in_if;
  import u8d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              stream_end;
  modport source (output valid, output byte_in, output stream_end, input ready);
  modport sink   (input valid, input byte_in, input stream_end, output ready);
endinterface

interface u8d_out_if;
  import u8d_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            invalid;
  logic            run_last;
  modport source (output valid, output code_point, output invalid, output run_last,
                  input ready);
  modport sink   (input valid, input code_point, input invalid, input run_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/u8d_decode.sv -----
// Decode stage: sequence state, per-byte decode into a result list, and the
// holding register that passes the list on. Depends on u8d_pkg and u8d_in_if.
`default_nettype none

module u8d_decode (
  input  wire                 clk,
  input  wire                 rst_n,
  u8d_in_if.sink              in_ch,
  input  wire                 take,
  output logic                h_valid,
  output u8d_pkg::u8d_list_t  h_list
);
  import u8d_pkg::*;

  // sequence state
  logic [BYTE_W-1:0] pend_r [3];
  logic [1:0]        pcnt_r, pcnt_nxt;
  logic [2:0]        elen_r, elen_nxt;
  logic              h_v_r;
  u8d_list_t         h_list_r;

  logic [BYTE_W-1:0] b;
  logic              acc, is_tail, complete, ok;
  logic [CP_W-1:0]   cp;
  logic [1:0]        fl;
  logic              item_v;
  u8d_res_t          item;
  logic              store_tail, store_lead;
  logic [2:0]        lead_len;
  u8d_list_t         list;

  assign b     = in_ch.byte_in;
  assign acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !h_v_r || take;

  assign is_tail  = (b[7:6] == TAIL_TAG);
  assign complete = ({1'b0, pcnt_r} + 3'd1) >= elen_r;

  // assemble the finished sequence and check range
  always_comb begin
    case (elen_r)
      LEN_2: begin
        cp = {10'd0, pend_r[0][4:0], b[5:0]};
        ok = cp >= MIN_CP2;
      end
      LEN_3: begin
        cp = {5'd0, pend_r[0][3:0], pend_r[1][5:0], b[5:0]};
        ok = (cp >= MIN_CP3) && (cp[15:11] != SURR_TAG);
      end
      default: begin
        cp = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], b[5:0]};
        ok = (cp >= MIN_CP4) && (cp <= MAX_CP);
      end
    endcase
  end

  // lead byte class
  always_comb begin
    if (b[7:5] == LEAD2_TAG)      lead_len = LEN_2;
    else if (b[7:4] == LEAD3_TAG) lead_len = LEN_3;
    else if (b[7:3] == LEAD4_TAG) lead_len = LEN_4;
    else                          lead_len = LEN_IDLE;
  end

  // decode: flush count of buffered bytes, then at most one trailing entry
  always_comb begin
    fl         = 2'd0;
    item_v     = 1'b0;
    item       = '{cp: {13'd0, b}, inv: 1'b1};
    store_tail = 1'b0;
    store_lead = 1'b0;
    pcnt_nxt   = 2'd0;
    elen_nxt   = LEN_IDLE;
    if (pcnt_r != 2'd0 && is_tail) begin
      if (complete) begin
        if (ok) begin
          item_v = 1'b1;
          item   = '{cp: cp, inv: 1'b0};
        end else begin
          fl     = pcnt_r;
          item_v = 1'b1;
        end
      end else if (in_ch.stream_end) begin
        // tail still short at end of stream: flush everything raw
        fl     = pcnt_r;
        item_v = 1'b1;
      end else begin
        store_tail = 1'b1;
        pcnt_nxt   = pcnt_r + 2'd1;
        elen_nxt   = elen_r;
      end
    end else begin
      fl = pcnt_r;
      if (!b[7]) begin
        item_v = 1'b1;
        item   = '{cp: {13'd0, b}, inv: 1'b0};
      end else if (lead_len != LEN_IDLE) begin
        if (in_ch.stream_end) begin
          item_v = 1'b1;
        end else begin
          store_lead = 1'b1;
          pcnt_nxt   = 2'd1;
          elen_nxt   = lead_len;
        end
      end else begin
        item_v = 1'b1;
      end
    end
  end

  // build the result list
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      list.ent[i] = '{cp: {13'd0, pend_r[i]}, inv: 1'b1};
    end
    list.ent[3]  = '0;
    list.ent[fl] = item;
    list.cnt     = {1'b0, fl} + {2'd0, item_v};
  end

  // state and holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      elen_r <= LEN_IDLE;
      h_v_r  <= 1'b0;
    end else if (acc) begin
      pcnt_r <= pcnt_nxt;
      elen_r <= elen_nxt;
      h_v_r  <= (list.cnt != '0);
    end else if (take) begin
      h_v_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      h_list_r <= list;
      if (store_lead) pend_r[0] <= b;
      if (store_tail) pend_r[pcnt_r] <= b;
    end
  end

  assign h_valid = h_v_r;
  assign h_list  = h_list_r;

endmodule

`default_nettype wire

// ----- rtl/u8d_burst.sv -----
// Output burst buffer: holds one result list and drains it one entry per
// transaction, marking the last. Depends on u8d_pkg and u8d_out_if.
`default_nettype none

module u8d_burst (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 h_valid,
  input  u8d_pkg::u8d_list_t  h_list,
  output logic                take,
  u8d_out_if.source           out_ch
);
  import u8d_pkg::*;

  u8d_res_t         ent_r [MAX_RES];
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       rd_r;
  logic             out_acc;

  assign out_acc = out_ch.valid && out_ch.ready;
  // load when empty or when the final entry leaves this cycle
  assign take = h_valid && ((cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 2'd0;
    end else if (take) begin
      cnt_r <= h_list.cnt;
      rd_r  <= 2'd0;
    end else if (out_acc) begin
      cnt_r <= cnt_r - CNT_W'(1);
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RES; i++) begin
        ent_r[i] <= h_list.ent[i];
      end
    end
  end

  // current entry to the port
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.code_point = ent_r[rd_r].cp;
  assign out_ch.invalid    = ent_r[rd_r].inv;
  assign out_ch.run_last   = (cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder_unit.sv -----
// UTF-8 stream decoder, one byte per transaction in, 0 to 4 results out.
// Each accepted byte's results pass through the decode holding register, then the output burst buffer.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready;
// a byte yielding several results holds the output burst buffer until all of them are taken.
// Reset clears the sequence count, length and valid flags; buffered bytes are not cleared.
// Depends on u8d_pkg, u8d_if, u8d_decode and u8d_burst.
`default_nettype none

module utf8_stream_decoder_unit (
  input  wire        clk,
  input  wire        rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);
  import u8d_pkg::*;

  logic      h_valid;
  logic      take;
  u8d_list_t h_list;

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take    (take),
    .h_valid (h_valid),
    .h_list  (h_list)
  );

  u8d_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .h_valid (h_valid),
    .h_list  (h_list),
    .take    (take),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_unit: a byte driver and a result
// monitor on clocked always blocks, checked against a built-in UTF-8 decode predictor.
// Depends on u8d_pkg, u8d_in_if, u8d_out_if and the decoder RTL.

module tb_top;
  import u8d_pkg::*;

  localparam int N_RANDOM    = 480;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYC   = 16;
  localparam int HOLD_CYC    = 400;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              fin;
  } byte_item_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
    logic            last;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_stream_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Stimulus and expectation stores
  byte_item_t byte_q[$];
  cp_result_t cp_due_q[$];
  cp_result_t burst_q[$];

  // Predictor state: gathered sequence bytes, count and target length
  logic [BYTE_W-1:0] seq_buf [3];
  int unsigned       seq_cnt;
  logic [2:0]        seq_len;

  int unsigned total_bytes;
  int unsigned bytes_offered;
  int unsigned bytes_taken;
  int unsigned results_seen;
  int unsigned bad_seen;
  int unsigned ends_seen;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  logic        hold_done;
  logic        quiet;

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------------
  task automatic push_cp(input logic [CP_W-1:0] cp, input logic bad);
    cp_result_t r;
    r.cp   = cp;
    r.bad  = bad;
    r.last = 1'b0;
    burst_q.push_back(r);
  endtask

  // emit every gathered byte raw and flagged, then go idle
  task automatic flush_seq();
    for (int i = 0; i < seq_cnt; i++)
      push_cp(CP_W'(seq_buf[i]), 1'b1);
    seq_cnt = 0;
    seq_len = LEN_IDLE;
  endtask

  // sequence is complete with byte b: range, surrogate and overlong checks happen here
  task automatic close_seq(input logic [BYTE_W-1:0] b);
    logic [CP_W-1:0] c;
    logic            ok;
    c  = '0;
    ok = 1'b0;
    case (seq_len)
      LEN_2: begin
        c  = CP_W'({seq_buf[0][4:0], b[5:0]});
        ok = (c >= MIN_CP2);
      end
      LEN_3: begin
        c  = CP_W'({seq_buf[0][3:0], seq_buf[1][5:0], b[5:0]});
        ok = (c >= MIN_CP3) && (c[15:11] != SURR_TAG);
      end
      default: begin
        c  = CP_W'({seq_buf[0][2:0], seq_buf[1][5:0], seq_buf[2][5:0], b[5:0]});
        ok = (c >= MIN_CP4) && (c <= MAX_CP);
      end
    endcase
    if (ok) begin
      push_cp(c, 1'b0);
      seq_cnt = 0;
      seq_len = LEN_IDLE;
    end else begin
      flush_seq();
      push_cp(CP_W'(b), 1'b1);
    end
  endtask

  task automatic predict_decode(input logic [BYTE_W-1:0] b, input logic fin);
    logic       done;
    logic [2:0] lead_len;
    done     = 1'b0;
    lead_len = LEN_IDLE;
    burst_q.delete();

    if (seq_cnt > 0) begin
      if (b[7:6] == TAIL_TAG) begin
        done = 1'b1;
        if (seq_cnt + 1 >= seq_len) begin
          close_seq(b);
        end else begin
          seq_buf[seq_cnt] = b;
          seq_cnt++;
          if (fin)
            flush_seq();
        end
      end else begin
        // broken sequence: dump the buffer, then decode this byte afresh
        flush_seq();
      end
    end

    if (!done) begin
      if (b[7] == 1'b0)
        push_cp(CP_W'(b), 1'b0);
      else if (b[7:5] == LEAD2_TAG)
        lead_len = LEN_2;
      else if (b[7:4] == LEAD3_TAG)
        lead_len = LEN_3;
      else if (b[7:3] == LEAD4_TAG)
        lead_len = LEN_4;
      else
        push_cp(CP_W'(b), 1'b1);
      if (lead_len != LEN_IDLE) begin
        seq_buf[0] = b;
        seq_cnt    = 1;
        seq_len    = lead_len;
        if (fin)
          flush_seq();
      end
    end

    if (burst_q.size() > 0)
      burst_q[burst_q.size()-1].last = 1'b1;
    foreach (burst_q[i])
      cp_due_q.push_back(burst_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic fin);
    byte_item_t it;
    it.val = b;
    it.fin = fin;
    byte_q.push_back(it);
  endtask

  function automatic logic rand_fin();
    return ($urandom_range(99) < 4);
  endfunction

  // continuation byte, now and then replaced by an arbitrary byte
  function automatic logic [BYTE_W-1:0] rand_tail();
    if ($urandom_range(99) < 5)
      return BYTE_W'($urandom_range(255));
    return BYTE_W'(8'h80 | $urandom_range(63));
  endfunction

  task automatic add_sequence();
    int unsigned       kind;
    int unsigned       n_tail;
    logic [BYTE_W-1:0] lead;
    kind   = $urandom_range(99);
    n_tail = 0;
    lead   = '0;
    if (kind < 20) begin
      add_byte(BYTE_W'($urandom_range(127)), rand_fin());
    end else if (kind >= 90) begin
      add_byte(BYTE_W'($urandom_range(255)), rand_fin());
    end else begin
      case ($urandom_range(2))
        0: begin
          lead   = BYTE_W'(8'hC0 | $urandom_range(31));
          n_tail = 1;
        end
        1: begin
          lead   = BYTE_W'(8'hE0 | $urandom_range(15));
          n_tail = 2;
        end
        default: begin
          // mostly legal 4-byte leads, some of the late-rejected ones
          if ($urandom_range(9) < 8)
            lead = BYTE_W'(8'hF0 + $urandom_range(4));
          else
            lead = BYTE_W'(8'hF0 + $urandom_range(7, 5));
          n_tail = 3;
        end
      endcase
      // truncated sequence: normally broken by the next sequence or by a stream end
      if (kind >= 78)
        n_tail = $urandom_range(n_tail - 1);
      add_byte(lead, (n_tail == 0) ? rand_fin() : 1'b0);
      for (int i = 0; i < n_tail; i++)
        add_byte(rand_tail(), (i == n_tail - 1) ? rand_fin() : 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes at the falling edge, holds until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    byte_item_t nxt;
    if (rst_n && bytes_taken == bytes_offered) begin
      if (byte_q.size() > 0 && (quiet || $urandom_range(99) >= 36)) begin
        nxt = byte_q.pop_front();
        in_ch.byte_in    <= nxt.val;
        in_ch.stream_end <= nxt.fin;
        in_ch.valid      <= 1'b1;
        bytes_offered++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // no idling on either side over a middle stretch of the run
  assign quiet = (bytes_taken >= 260) && (bytes_taken < 360);

  // long receiver hold-off, once, so the block backs up into its input
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= 120) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result-side ready
  always @(negedge clk) begin
    if (rst_n)
      out_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 36);
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result transactions, feeds accepted bytes to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.invalid)
          bad_seen++;
        if (cp_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result cp=%h invalid=%b",
                                    out_ch.code_point, out_ch.invalid));
        end else begin
          want = cp_due_q.pop_front();
          if (out_ch.code_point !== want.cp)
            report_mismatch($sformatf("code_point %h, expected %h",
                                      out_ch.code_point, want.cp));
          if (out_ch.invalid !== want.bad)
            report_mismatch($sformatf("invalid %b, expected %b (cp %h)",
                                      out_ch.invalid, want.bad, want.cp));
          if (out_ch.run_last !== want.last)
            report_mismatch($sformatf("run_last %b, expected %b (cp %h)",
                                      out_ch.run_last, want.last, want.cp));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.stream_end)
          ends_seen++;
        predict_decode(in_ch.byte_in, in_ch.stream_end);
        bytes_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               cp_due_q.size());
      $display("FAIL utf8_stream_decoder_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.byte_in    = '0;
    in_ch.stream_end = 1'b0;
    out_ch.ready     = 1'b0;
    seq_cnt          = 0;
    seq_len          = LEN_IDLE;
    bytes_offered    = 0;
    bytes_taken      = 0;
    results_seen     = 0;
    bad_seen         = 0;
    ends_seen        = 0;
    err_cnt          = 0;
    cycle_cnt        = 0;

    // ASCII extremes
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    // two-byte scalar
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    // largest legal scalar
    add_byte(8'hF4, 1'b0);
    add_byte(8'h8F, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    // just above the scalar range
    add_byte(8'hF4, 1'b0);
    add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    // overlong two-byte form, accepted lead then rejected at the end
    add_byte(8'hC0, 1'b0);
    add_byte(8'h80, 1'b0);
    // surrogate
    add_byte(8'hED, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'h80, 1'b0);
    // bytes that cannot start a sequence
    add_byte(8'hBF, 1'b0);
    add_byte(8'hFF, 1'b0);
    // sequence broken by an ASCII byte
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    // stream ends inside a sequence, and on a bare lead
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b1);
    add_byte(8'hC3, 1'b1);

    while (byte_q.size() < 24 + N_RANDOM)
      add_sequence();
    total_bytes = byte_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all bytes in, all results back, then a quiet tail for strays
    while (bytes_taken < total_bytes || cp_due_q.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("run covered %0d bytes (%0d stream ends), %0d results, %0d flagged invalid",
             bytes_taken, ends_seen, results_seen, bad_seen);
    $display("input stalled behind a %0d-cycle output hold-off; %0d mismatches",
             HOLD_CYC, err_cnt);
    if (err_cnt == 0)
      $display("PASS utf8_stream_decoder_unit");
    else
      $display("FAIL utf8_stream_decoder_unit");
    $finish;
  end

endmodule
